// ----- sv/scheduled_sine_voice_mixer_macros.svh -----
// assertion macros for the voice mixer
`ifndef SCHEDULED_SINE_VOICE_MIXER_MACROS_SVH
`define SCHEDULED_SINE_VOICE_MIXER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SSVM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SSVM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ssvm_pkg.sv -----
// shared constants of the voice mixer
package ssvm_pkg;

  // request codes
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // add status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ENDED      = 2'd1;
  localparam logic [1:0] ST_POOL_FULL  = 2'd2;
  localparam logic [1:0] ST_QUEUE_FULL = 2'd3;

  // sine phase: 2^SINE_BITS steps over one sine period
  localparam int SINE_BITS = 10;

  // polynomial coefficients of the quarter wave
  localparam logic [11:0] SINE_C1 = 12'd2464;
  localparam logic [14:0] SINE_C0 = 15'd21168;
  localparam logic [15:0] SINE_C2 = 16'd51472;
  localparam logic [14:0] SINE_MAX = 15'd32767;

  localparam logic [16:0] W_FULL = 17'd32768;

endpackage

// ----- sv/ssvm_ram.sv -----
// generic single-port-write ram with registered read
module ssvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/scheduled_sine_voice_mixer.sv -----
// voice mixer top level: note scheduler, sine voices and mix
//
// Input channel (in_valid/in_ready) takes one request word: an add of a note
// (start, stop, pitch, volume) or a tick. Every request gives exactly one
// result word on the out_ channel (sample, status, event count, queue free,
// idle). The cfg_ channel writes the master gain, always ready.
// An add is checked in S_ADD and goes to the result register from S_DONE. A
// tick steps each active voice through S_VRD to S_VACC (at most one multiply
// per state, stepped through the phase, sine polynomial and gain products),
// then S_TEND; at a rehash point a sweep reads each active voice and each
// queued note in turn through the single read port of each pool memory.
// A new request is taken the cycle after the result register is loaded.
// Active pool and waiting queue each live in one ram; ended voices are
// replaced by the last entry and due notes are copied across.
// Reset clears counts, time and result valid, sets the rehash point to all
// ones and the gain to full scale. No ram clearing is needed. A result waits
// in the output register while the receiver stalls; the next request is taken
// only when the block returns to idle after handing its word to that register.
`include "scheduled_sine_voice_mixer_macros.svh"

module scheduled_sine_voice_mixer #(
  parameter int VOICES      = 16,
  parameter int QUEUE_DEPTH = 32,
  parameter int TIME_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [31:0]        in_note_start,
  input  logic [31:0]        in_note_stop,
  input  logic [15:0]        in_note_pitch,
  input  logic [15:0]        in_note_volume,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [19:0] out_sample,
  output logic [1:0]         out_status,
  output logic signed [6:0]  out_event_count,
  output logic [5:0]         out_queue_free,
  output logic               out_idle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  localparam int TB     = TIME_BITS;
  localparam int ENT_W  = 2 * TB + 32;
  localparam int A_AW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int W_AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int AU_W   = $clog2(VOICES + 1);
  localparam int WU_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int MAXD   = (VOICES > QUEUE_DEPTH) ? VOICES : QUEUE_DEPTH;
  localparam int IDX_W  = $clog2(MAXD + 1);
  localparam int CNT_W  = $clog2(VOICES + QUEUE_DEPTH + 1);
  localparam int EV_W   = (CNT_W + 2 > 8) ? CNT_W + 2 : 8;
  localparam int ACC_R  = 17 + $clog2(VOICES + 1);
  localparam int ACC_W  = (ACC_R > 21) ? ACC_R : 21;
  localparam int QF_W   = WU_W + 6;
  localparam int KB     = ssvm_pkg::SINE_BITS;

  localparam logic signed [ACC_W-1:0] SMP_MAX = ACC_W'(524287);
  localparam logic signed [ACC_W-1:0] SMP_MIN = ACC_W'(-524288);
  localparam logic signed [EV_W-1:0]  EV_MAX  = EV_W'(63);
  localparam logic signed [EV_W-1:0]  EV_MIN  = EV_W'(-64);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ADD  = 5'd1;
  localparam logic [4:0] S_VRD  = 5'd2;
  localparam logic [4:0] S_VPH  = 5'd3;
  localparam logic [4:0] S_VW   = 5'd4;
  localparam logic [4:0] S_VU2  = 5'd5;
  localparam logic [4:0] S_VT   = 5'd6;
  localparam logic [4:0] S_VT2  = 5'd7;
  localparam logic [4:0] S_VS   = 5'd8;
  localparam logic [4:0] S_VACC = 5'd9;
  localparam logic [4:0] S_TEND = 5'd10;
  localparam logic [4:0] S_ARD  = 5'd11;
  localparam logic [4:0] S_ACHK = 5'd12;
  localparam logic [4:0] S_AMOV = 5'd13;
  localparam logic [4:0] S_WRD  = 5'd14;
  localparam logic [4:0] S_WCHK = 5'd15;
  localparam logic [4:0] S_WMOV = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  // control registers
  logic [4:0]      state_r, state_nxt;
  logic [TB-1:0]   now_r, now_nxt;
  logic [TB-1:0]   rehash_r, rehash_nxt;
  logic [AU_W-1:0] aused_r, aused_nxt;
  logic [WU_W-1:0] wused_r, wused_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     master_gain_r, master_gain_nxt;

  // datapath registers
  logic [TB-1:0]          start_r, start_nxt;
  logic [TB-1:0]          stop_r, stop_nxt;
  logic [15:0]            pitch_r, pitch_nxt;
  logic [15:0]            volume_r, volume_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [15:0]            phase_r, phase_nxt;
  logic [15:0]            vgain_r, vgain_nxt;
  logic [1:0]             quad_r, quad_nxt;
  logic [16:0]            w_r, w_nxt;
  logic [15:0]            u2_r, u2_nxt;
  logic [14:0]            t_r, t_nxt;
  logic [15:0]            t2_r, t2_nxt;
  logic signed [15:0]     s_r, s_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [19:0]     sample_r, sample_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [CNT_W-1:0]       retired_r, retired_nxt;
  logic [CNT_W-1:0]       moved_r, moved_nxt;
  logic [CNT_W-1:0]       failed_r, failed_nxt;
  logic [TB-1:0]          soon_r, soon_nxt;
  logic signed [19:0]     out_sample_r, out_sample_nxt;
  logic [1:0]             out_status_r, out_status_nxt;
  logic signed [6:0]      out_event_count_r, out_event_count_nxt;
  logic [5:0]             out_queue_free_r, out_queue_free_nxt;
  logic                   out_idle_r, out_idle_nxt;

  // ram ports
  logic             act_we, wt_we;
  logic [A_AW-1:0]  act_waddr, act_raddr;
  logic [W_AW-1:0]  wt_waddr, wt_raddr;
  logic [ENT_W-1:0] act_wdata, act_rdata, wt_wdata, wt_rdata;

  ssvm_ram #(.WIDTH(ENT_W), .DEPTH(VOICES)) u_active (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .raddr(act_raddr), .rdata(act_rdata)
  );

  ssvm_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_waiting (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
    .raddr(wt_raddr), .rdata(wt_rdata)
  );

  // entry fields
  logic [TB-1:0] a_begin, a_end, w_begin, w_end;
  logic [15:0]   a_step, a_gain;
  assign a_begin = act_rdata[ENT_W-1 -: TB];
  assign a_end   = act_rdata[ENT_W-TB-1 -: TB];
  assign a_step  = act_rdata[31:16];
  assign a_gain  = act_rdata[15:0];
  assign w_begin = wt_rdata[ENT_W-1 -: TB];
  assign w_end   = wt_rdata[ENT_W-TB-1 -: TB];

  // add path
  logic [31:0]      add_prod;
  logic [15:0]      add_gain;
  logic [1:0]       add_status;
  logic             add_active;
  logic [ENT_W-1:0] add_entry;
  assign add_prod  = volume_r * master_gain_r;
  assign add_gain  = add_prod[31:16];
  assign add_entry = {start_r, stop_r, pitch_r, add_gain};
  always_comb begin
    add_active = 1'b0;
    if (stop_r <= now_r) begin
      add_status = ssvm_pkg::ST_ENDED;
    end else if (start_r <= now_r) begin
      add_active = 1'b1;
      add_status = (aused_r == AU_W'(VOICES)) ? ssvm_pkg::ST_POOL_FULL : ssvm_pkg::ST_OK;
    end else begin
      add_status = (wused_r == WU_W'(QUEUE_DEPTH)) ? ssvm_pkg::ST_QUEUE_FULL
                                                    : ssvm_pkg::ST_OK;
    end
  end

  // voice arithmetic, at most one multiply per state
  logic [TB-1:0]       diff;
  logic [31:0]         ph_prod;
  logic [KB-1:0]       k;
  logic [14:0]         u;
  logic [33:0]         sq_prod;
  logic [27:0]         c1_prod;
  logic [30:0]         ut_prod;
  logic [32:0]         s_prod;
  logic [14:0]         s_mag;
  logic signed [32:0]  term_prod;
  logic signed [16:0]  term;
  logic [TB-1:0]       now_inc;
  assign diff    = now_r - a_begin;
  assign ph_prod = diff[15:0] * a_step;
  assign k       = phase_r[15 -: KB];
  assign u       = {k[KB-3:0], {(17 - KB){1'b0}}};
  assign sq_prod = w_r * w_r;
  assign c1_prod = u2_r * ssvm_pkg::SINE_C1;
  assign ut_prod = u2_r * t_r;
  assign s_prod  = w_r * t2_r;
  assign s_mag   = (s_prod[32:15] > 18'(ssvm_pkg::SINE_MAX)) ? ssvm_pkg::SINE_MAX
                                                              : s_prod[29:15];
  assign term_prod = $signed({1'b0, vgain_r}) * s_r;
  assign term      = term_prod[32:16];
  assign now_inc   = now_r + 1'b1;

  // result words
  logic signed [EV_W-1:0] ev;
  logic [WU_W-1:0]        qfree;
  logic [QF_W-1:0]        qfree_ext;
  assign ev = EV_W'(retired_r) + ((failed_r != '0) ? (EV_W'(0) - EV_W'(failed_r))
                                                    : EV_W'(moved_r));
  assign qfree     = WU_W'(QUEUE_DEPTH) - wused_r;
  assign qfree_ext = QF_W'(qfree);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt           = state_r;
    now_nxt             = now_r;
    rehash_nxt          = rehash_r;
    aused_nxt           = aused_r;
    wused_nxt           = wused_r;
    out_valid_nxt       = out_valid_r & ~out_ready;
    master_gain_nxt     = cfg_valid ? cfg_data : master_gain_r;
    start_nxt           = start_r;
    stop_nxt            = stop_r;
    pitch_nxt           = pitch_r;
    volume_nxt          = volume_r;
    idx_nxt             = idx_r;
    phase_nxt           = phase_r;
    vgain_nxt           = vgain_r;
    quad_nxt            = quad_r;
    w_nxt               = w_r;
    u2_nxt              = u2_r;
    t_nxt               = t_r;
    t2_nxt              = t2_r;
    s_nxt               = s_r;
    acc_nxt             = acc_r;
    sample_nxt          = sample_r;
    status_nxt          = status_r;
    retired_nxt         = retired_r;
    moved_nxt           = moved_r;
    failed_nxt          = failed_r;
    soon_nxt            = soon_r;
    out_sample_nxt      = out_sample_r;
    out_status_nxt      = out_status_r;
    out_event_count_nxt = out_event_count_r;
    out_queue_free_nxt  = out_queue_free_r;
    out_idle_nxt        = out_idle_r;
    act_we    = 1'b0;
    act_waddr = idx_r[A_AW-1:0];
    act_wdata = act_rdata;
    act_raddr = idx_r[A_AW-1:0];
    wt_we     = 1'b0;
    wt_waddr  = idx_r[W_AW-1:0];
    wt_wdata  = wt_rdata;
    wt_raddr  = idx_r[W_AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          start_nxt   = TB'(in_note_start);
          stop_nxt    = TB'(in_note_stop);
          pitch_nxt   = in_note_pitch;
          volume_nxt  = in_note_volume;
          idx_nxt     = '0;
          acc_nxt     = '0;
          sample_nxt  = '0;
          status_nxt  = ssvm_pkg::ST_OK;
          retired_nxt = '0;
          moved_nxt   = '0;
          failed_nxt  = '0;
          if (in_req_type == ssvm_pkg::REQ_ADD) begin
            state_nxt = S_ADD;
          end else if (aused_r == '0) begin
            state_nxt = S_TEND;
          end else begin
            state_nxt = S_VRD;
          end
        end
      end
      S_ADD: begin
        status_nxt = add_status;
        if (add_status == ssvm_pkg::ST_OK) begin
          if (add_active) begin
            act_we    = 1'b1;
            act_waddr = aused_r[A_AW-1:0];
            act_wdata = add_entry;
            aused_nxt = aused_r + 1'b1;
          end else begin
            wt_we     = 1'b1;
            wt_waddr  = wused_r[W_AW-1:0];
            wt_wdata  = add_entry;
            wused_nxt = wused_r + 1'b1;
          end
          if (rehash_r > start_r) begin
            rehash_nxt = start_r;
          end
        end
        state_nxt = S_DONE;
      end
      S_VRD: state_nxt = S_VPH;
      S_VPH: begin
        phase_nxt = ph_prod[15:0];
        vgain_nxt = a_gain;
        state_nxt = S_VW;
      end
      S_VW: begin
        quad_nxt  = k[KB-1 -: 2];
        w_nxt     = k[KB-2] ? (ssvm_pkg::W_FULL - {2'b00, u}) : {2'b00, u};
        state_nxt = S_VU2;
      end
      S_VU2: begin
        u2_nxt    = sq_prod[30:15];
        state_nxt = S_VT;
      end
      S_VT: begin
        t_nxt     = ssvm_pkg::SINE_C0 - c1_prod[27:15];
        state_nxt = S_VT2;
      end
      S_VT2: begin
        t2_nxt    = ssvm_pkg::SINE_C2 - ut_prod[30:15];
        state_nxt = S_VS;
      end
      S_VS: begin
        s_nxt     = quad_r[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
        state_nxt = S_VACC;
      end
      S_VACC: begin
        acc_nxt = acc_r + ACC_W'(term);
        idx_nxt = idx_r + 1'b1;
        if ((idx_r + 1'b1) >= IDX_W'(aused_r)) begin
          state_nxt = S_TEND;
        end else begin
          state_nxt = S_VRD;
        end
      end
      S_TEND: begin
        if (acc_r > SMP_MAX) begin
          sample_nxt = SMP_MAX[19:0];
        end else if (acc_r < SMP_MIN) begin
          sample_nxt = SMP_MIN[19:0];
        end else begin
          sample_nxt = acc_r[19:0];
        end
        now_nxt = now_inc;
        if (now_inc >= rehash_r) begin
          idx_nxt   = '0;
          soon_nxt  = '1;
          state_nxt = S_ARD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // retire ended voices, last entry fills the hole
      S_ARD: begin
        if (idx_r >= IDX_W'(aused_r)) begin
          idx_nxt   = '0;
          state_nxt = S_WRD;
        end else begin
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        if (a_end <= now_r) begin
          retired_nxt = retired_r + 1'b1;
          aused_nxt   = aused_r - 1'b1;
          act_raddr   = aused_nxt[A_AW-1:0];
          state_nxt   = S_AMOV;
        end else begin
          if (a_end < soon_r) begin
            soon_nxt = a_end;
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_ARD;
        end
      end
      S_AMOV: begin
        act_we    = 1'b1;
        state_nxt = S_ARD;
      end
      // move due queued notes into the pool
      S_WRD: begin
        if (idx_r >= IDX_W'(wused_r)) begin
          rehash_nxt = soon_r;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_WCHK;
        end
      end
      S_WCHK: begin
        if (w_begin <= now_r && aused_r != AU_W'(VOICES)) begin
          act_we    = 1'b1;
          act_waddr = aused_r[A_AW-1:0];
          act_wdata = wt_rdata;
          aused_nxt = aused_r + 1'b1;
          moved_nxt = moved_r + 1'b1;
          if (w_end < soon_r) begin
            soon_nxt = w_end;
          end
          wused_nxt = wused_r - 1'b1;
          wt_raddr  = wused_nxt[W_AW-1:0];
          state_nxt = S_WMOV;
        end else begin
          if (w_begin <= now_r) begin
            failed_nxt = failed_r + 1'b1;
          end
          if (w_begin < soon_r) begin
            soon_nxt = w_begin;
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_WRD;
        end
      end
      S_WMOV: begin
        wt_we     = 1'b1;
        state_nxt = S_WRD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = sample_r;
          out_status_nxt = status_r;
          if (ev > EV_MAX) begin
            out_event_count_nxt = EV_MAX[6:0];
          end else if (ev < EV_MIN) begin
            out_event_count_nxt = EV_MIN[6:0];
          end else begin
            out_event_count_nxt = ev[6:0];
          end
          out_queue_free_nxt = (qfree_ext > QF_W'(63)) ? 6'd63 : qfree_ext[5:0];
          out_idle_nxt       = (aused_r == '0) && (wused_r == '0);
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      now_r         <= '0;
      rehash_r      <= '1;
      aused_r       <= '0;
      wused_r       <= '0;
      out_valid_r   <= 1'b0;
      master_gain_r <= 16'hFFFF;
    end else begin
      state_r       <= state_nxt;
      now_r         <= now_nxt;
      rehash_r      <= rehash_nxt;
      aused_r       <= aused_nxt;
      wused_r       <= wused_nxt;
      out_valid_r   <= out_valid_nxt;
      master_gain_r <= master_gain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r           <= start_nxt;
    stop_r            <= stop_nxt;
    pitch_r           <= pitch_nxt;
    volume_r          <= volume_nxt;
    idx_r             <= idx_nxt;
    phase_r           <= phase_nxt;
    vgain_r           <= vgain_nxt;
    quad_r            <= quad_nxt;
    w_r               <= w_nxt;
    u2_r              <= u2_nxt;
    t_r               <= t_nxt;
    t2_r              <= t2_nxt;
    s_r               <= s_nxt;
    acc_r             <= acc_nxt;
    sample_r          <= sample_nxt;
    status_r          <= status_nxt;
    retired_r         <= retired_nxt;
    moved_r           <= moved_nxt;
    failed_r          <= failed_nxt;
    soon_r            <= soon_nxt;
    out_sample_r      <= out_sample_nxt;
    out_status_r      <= out_status_nxt;
    out_event_count_r <= out_event_count_nxt;
    out_queue_free_r  <= out_queue_free_nxt;
    out_idle_r        <= out_idle_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_status      = out_status_r;
  assign out_event_count = out_event_count_r;
  assign out_queue_free  = out_queue_free_r;
  assign out_idle        = out_idle_r;

  `SSVM_ASSERT(a_pool_bound, 1'b1, aused_r <= AU_W'(VOICES), "active count past pool size")
  `SSVM_ASSERT(a_queue_bound, 1'b1, wused_r <= WU_W'(QUEUE_DEPTH), "queue count past depth")
  `SSVM_ASSERT_NXT(a_tick_step, state_r == S_TEND, now_r == TB'($past(now_r) + 1'b1),
                   "time did not advance by one on a tick")
  `SSVM_ASSERT_NXT(a_done_hold, state_r == S_DONE && out_valid_r && !out_ready,
                   state_r == S_DONE, "result dropped while output stalled")

endmodule
